### rtl/stx_pkg.sv
`timescale 1ns / 1ps
// Package for the STX/ETX frame encoder: line control codes, the queue entry
// type and the CRC-16 and byte-stuffing helpers. Depends on nothing.
package stx_pkg;

    localparam logic [7:0]  ChStx   = 8'h02;
    localparam logic [7:0]  ChEtx   = 8'h03;
    localparam logic [7:0]  ChDle   = 8'h10;
    localparam logic [7:0]  ChXon   = 8'h11;
    localparam logic [7:0]  ChXoff  = 8'h13;
    localparam logic [7:0]  StuffOr = 8'h40;
    localparam logic [15:0] CrcPoly = 16'h1021;
    localparam logic [15:0] CrcTop  = 16'h8000;

    typedef struct packed {
        logic        stx;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] byte_in);
        logic [15:0] c;
        c = crc_in ^ {byte_in, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if ((c & CrcTop) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CrcAfterStx = crc_byte(16'h0000, ChStx);

    function automatic logic needs_stuff(input logic [7:0] byte_in);
        return byte_in inside {ChStx, ChEtx, ChDle, ChXon, ChXoff};
    endfunction

endpackage

### rtl/stx_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the frame encoder: payload input,
// line-byte output and the internal command queue. Depends on stx_pkg.
interface stx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface stx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_last;

    modport source (output valid, output line_byte, output run_last, input ready);
    modport sink   (input valid, input line_byte, input run_last, output ready);
endinterface

interface stx_cmd_if import stx_pkg::*;;
    logic valid;
    logic ready;
    t_cmd cmd;

    modport source (output valid, output cmd, input ready);
    modport sink   (input valid, input cmd, output ready);
endinterface

### rtl/stx_front.sv
`timescale 1ns / 1ps
// Front end: accepts payload items, tracks frame state and the running CRC,
// and hands a classified command to the queue. Depends on stx_pkg, stx_if.
module stx_front import stx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stx_in_if.sink      i_in,
    stx_cmd_if.source   o_cmd
);

    logic        r_in_frame;
    logic [15:0] r_crc;
    logic        n_in_frame;
    logic [15:0] n_crc;
    logic [15:0] crc_base;
    logic [15:0] crc_new;
    logic        accept;

    assign i_in.ready = o_cmd.ready;
    assign accept     = i_in.valid && o_cmd.ready;

    always_comb begin
        crc_base = r_in_frame ? r_crc : CrcAfterStx;
        crc_new  = crc_byte(crc_base, i_in.data_byte);

        o_cmd.valid    = i_in.valid;
        o_cmd.cmd.stx  = !r_in_frame;
        o_cmd.cmd.data = i_in.data_byte;
        o_cmd.cmd.last = i_in.frame_last;
        o_cmd.cmd.crc  = crc_new;

        n_in_frame = r_in_frame;
        n_crc      = r_crc;
        if (accept) begin
            if (i_in.frame_last) begin
                n_in_frame = 1'b0;
                n_crc      = 16'h0000;
            end else begin
                n_in_frame = 1'b1;
                n_crc      = crc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_crc      <= 16'h0000;
        end else begin
            r_in_frame <= n_in_frame;
            r_crc      <= n_crc;
        end
    end

endmodule

### rtl/stx_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on stx_pkg and stx_if.
module stx_queue import stx_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stx_cmd_if.sink     i_wr,
    stx_cmd_if.source   o_rd
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;
    logic            push;
    logic            pop;

    assign i_wr.ready = (r_count != CntW'(DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.cmd   = r_mem[r_rd_ptr];
    assign push       = i_wr.valid && i_wr.ready;
    assign pop        = o_rd.valid && o_rd.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/stx_back.sv
`timescale 1ns / 1ps
// Back end: steps each command via STX (if first), stuffed data, stuffed CRC and ETX
// (if last); a byte per unstalled cycle into an output register. Uses stx_pkg, stx_if.
module stx_back import stx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stx_cmd_if.sink     i_cmd,
    stx_out_if.source   o_out
);

    typedef enum logic [2:0] {
        PH_STX,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_ETX
    } t_phase;

    t_phase     r_phase;
    logic       r_started;
    logic       r_esc;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    t_phase     n_phase;
    logic       n_started;
    logic       n_esc;
    logic       n_out_valid;
    logic [7:0] n_out_byte;
    logic       n_out_last;

    t_phase     cur_phase;
    t_phase     next_phase;
    logic [7:0] cur_byte;
    logic       stuffable;
    logic       esc_first;
    logic       fin;
    logic       step;

    assign o_out.valid     = r_out_valid;
    assign o_out.line_byte = r_out_byte;
    assign o_out.run_last  = r_out_last;

    assign step        = i_cmd.valid && (!r_out_valid || o_out.ready);
    assign i_cmd.ready = step && fin;

    always_comb begin
        if (r_started) begin
            cur_phase = r_phase;
        end else if (i_cmd.cmd.stx) begin
            cur_phase = PH_STX;
        end else begin
            cur_phase = PH_DATA;
        end

        case (cur_phase)
            PH_STX: begin
                cur_byte   = ChStx;
                stuffable  = 1'b0;
                next_phase = PH_DATA;
            end
            PH_DATA: begin
                cur_byte   = i_cmd.cmd.data;
                stuffable  = 1'b1;
                next_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                cur_byte   = i_cmd.cmd.crc[15:8];
                stuffable  = 1'b1;
                next_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                cur_byte   = i_cmd.cmd.crc[7:0];
                stuffable  = 1'b1;
                next_phase = PH_ETX;
            end
            PH_ETX: begin
                cur_byte   = ChEtx;
                stuffable  = 1'b0;
                next_phase = PH_STX;
            end
            default: begin
                cur_byte   = ChEtx;
                stuffable  = 1'b0;
                next_phase = PH_STX;
            end
        endcase

        esc_first = stuffable && needs_stuff(cur_byte) && !r_esc;
        fin       = !esc_first &&
                    ((cur_phase == PH_ETX) || ((cur_phase == PH_DATA) && !i_cmd.cmd.last));

        n_phase     = r_phase;
        n_started   = r_started;
        n_esc       = r_esc;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (step) begin
            n_out_valid = 1'b1;
            n_out_last  = fin;
            if (esc_first) begin
                n_out_byte = ChDle;
                n_esc      = 1'b1;
                n_started  = 1'b1;
                n_phase    = cur_phase;
            end else begin
                n_out_byte = r_esc ? (cur_byte | StuffOr) : cur_byte;
                n_esc      = 1'b0;
                n_started  = !fin;
                n_phase    = next_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_STX;
            r_started   <= 1'b0;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_byte  <= 8'h00;
            r_out_last  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_started   <= n_started;
            r_esc       <= n_esc;
            r_out_valid <= n_out_valid;
            r_out_byte  <= n_out_byte;
            r_out_last  <= n_out_last;
        end
    end

endmodule

### rtl/stx_etx_frame_encoder_crc16.sv
`timescale 1ns / 1ps
// STX/ETX frame encoder with DLE byte stuffing and CRC-16 (poly 0x1021).
// Top level; depends on stx_pkg, stx_if, stx_front, stx_queue and stx_back.
//
// Input channel i_in carries one payload byte per item with frame_last set on
// the final byte of a frame. Output channel o_out carries one line byte per
// item; run_last marks the final line byte caused by an input item.
// The front end takes an item in any cycle in which the command queue has
// room, and updates the running CRC in that same cycle. The back end emits
// one line byte per cycle while the receiver is ready and commands wait:
// an ordinary byte yields one line byte, a stuffed byte two, and the opening
// STX and the trailer (stuffed CRC high and low, ETX) add one to six more,
// so an item yields between one and eight line bytes, typically one or two.
// An accepted item is written into the queue, and its first line byte is
// then loaded into the back end's output register before it is presented.
// Reset clears the frame state, the CRC, the queue and the output register.
// When the receiver holds ready low the output register keeps its byte, the
// back end pauses and the queue of QUEUE_DEPTH entries fills, after which
// i_in.ready falls.
module stx_etx_frame_encoder_crc16 import stx_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stx_in_if.sink      i_in,
    stx_out_if.source   o_out
);

    stx_cmd_if u_front_cmd ();
    stx_cmd_if u_back_cmd ();

    stx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (u_front_cmd)
    );

    stx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (u_front_cmd),
        .o_rd    (u_back_cmd)
    );

    stx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_back_cmd),
        .o_out   (o_out)
    );

endmodule

### bench/stx_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the STX/ETX frame encoder: watches the payload and line channels,
// predicts the framed, stuffed and CRC-protected line bytes and compares them.
// Depends on stx_pkg and the channel interfaces in stx_if.
module stx_frame_checker import stx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    stx_in_if    i_in,
    stx_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
    } t_line_item;

    t_line_item  line_fifo [$];
    logic        frame_open;
    logic [15:0] frame_crc;
    int          fail_total;

    initial begin
        frame_open = 1'b0;
        frame_crc  = 16'h0000;
        fail_total = 0;
    end

    // Bit-serial CRC-16/XMODEM, most significant data bit first.
    function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc_in,
                                                      input logic [7:0] data);
        logic [15:0] acc;
        logic        feedback;
        acc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            feedback = acc[15] ^ data[i];
            acc = {acc[14:0], 1'b0};
            if (feedback) begin
                acc = acc ^ CrcPoly;
            end
        end
        return acc;
    endfunction

    function automatic logic is_link_control(input logic [7:0] b);
        return (b == ChStx) || (b == ChEtx) || (b == ChDle) || (b == ChXon) || (b == ChXoff);
    endfunction

    task automatic add_line_byte(input logic [7:0] b);
        t_line_item item;
        item.line_byte = b;
        item.run_last  = 1'b0;
        line_fifo.push_back(item);
    endtask

    task automatic add_escaped(input logic [7:0] b);
        if (is_link_control(b)) begin
            add_line_byte(ChDle);
            add_line_byte(b | StuffOr);
        end else begin
            add_line_byte(b);
        end
    endtask

    task automatic encode_payload(input logic [7:0] data, input logic last);
        t_line_item tail;
        if (!frame_open) begin
            add_line_byte(ChStx);
            frame_crc  = crc16_xmodem_step(16'h0000, ChStx);
            frame_open = 1'b1;
        end
        add_escaped(data);
        frame_crc = crc16_xmodem_step(frame_crc, data);
        if (last) begin
            add_escaped(frame_crc[15:8]);
            add_escaped(frame_crc[7:0]);
            add_line_byte(ChEtx);
            frame_open = 1'b0;
            frame_crc  = 16'h0000;
        end
        tail = line_fifo.pop_back();
        tail.run_last = 1'b1;
        line_fifo.push_back(tail);
    endtask

    always @(posedge i_clk) begin
        t_line_item want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                encode_payload(i_in.data_byte, i_in.frame_last);
            end
            if (i_out.valid && i_out.ready) begin
                if (line_fifo.size() == 0) begin
                    $error("line_byte %02h arrived with nothing expected", i_out.line_byte);
                    fail_total++;
                end else begin
                    want = line_fifo.pop_front();
                    if (want.line_byte !== i_out.line_byte) begin
                        $error("line_byte: expected %02h, actual %02h",
                               want.line_byte, i_out.line_byte);
                        fail_total++;
                    end
                    if (want.run_last !== i_out.run_last) begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, i_out.run_last);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= line_fifo.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the frame encoder testbench: clock, reset, payload stimulus, line-side
// flow control, watchdog and verdict. Depends on stx_pkg, stx_if, the encoder
// and stx_frame_checker.
module tb_top import stx_pkg::*;;

    localparam int TargetItems   = 500;
    localparam int QuietFrom     = 420;
    localparam int LongHoldAt    = 200;
    localparam int LongHoldCount = 80;
    localparam int DrainCycles   = 16;
    localparam int IdleLimit     = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    logic quiet_tail;
    logic burst_mode;
    logic long_hold_req;

    stx_in_if  in_ch ();
    stx_out_if out_ch ();

    stx_etx_frame_encoder_crc16 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    stx_frame_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic offer_payload(input logic [7:0] b, input logic last);
        if (!quiet_tail && !burst_mode && $urandom_range(99, 0) < 12) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.frame_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic wait_line_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_random_frame(input int unsigned len);
        logic [7:0] b;
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(3, 0) == 0) begin
                case ($urandom_range(4, 0))
                    0:       b = ChStx;
                    1:       b = ChEtx;
                    2:       b = ChDle;
                    3:       b = ChXon;
                    default: b = ChXoff;
                endcase
            end else begin
                b = 8'($urandom_range(255, 0));
            end
            offer_payload(b, k == len - 1);
        end
    endtask

    initial begin : receiver
        int unsigned left;
        logic        hold_taken;
        left       = 0;
        hold_taken = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left != 0) begin
                left--;
            end else if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_ch.ready <= 1'b0;
                left = LongHoldCount - 1;
            end else if (!quiet_tail && $urandom_range(99, 0) < 10) begin
                out_ch.ready <= 1'b0;
                left = $urandom_range(18, 1) - 1;
            end else begin
                out_ch.ready <= 1'b1;
                left = $urandom_range(15, 0);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IdleLimit) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("stx_etx_frame_encoder_crc16 verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned len;
        logic        hold_done;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= 8'h00;
        in_ch.frame_last <= 1'b0;
        i_rst_n          <= 1'b0;
        long_hold_req    <= 1'b0;
        quiet_tail = 1'b0;
        burst_mode = 1'b0;
        hold_done  = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-byte frames: extremes, all escaped bytes, and plain 12h and 42h.
        offer_payload(8'h00, 1'b1);
        offer_payload(8'hFF, 1'b1);
        offer_payload(ChStx, 1'b1);
        offer_payload(ChEtx, 1'b1);
        offer_payload(ChDle, 1'b1);
        offer_payload(ChXon, 1'b1);
        offer_payload(ChXoff, 1'b1);
        offer_payload(8'h12, 1'b1);
        offer_payload(8'h42, 1'b1);
        // A longer frame mixing escaped and plain bytes.
        offer_payload(ChStx, 1'b0);
        offer_payload(ChEtx, 1'b0);
        offer_payload(ChDle, 1'b0);
        offer_payload(ChXon, 1'b0);
        offer_payload(ChXoff, 1'b0);
        offer_payload(8'hFF, 1'b0);
        offer_payload(8'h00, 1'b0);
        offer_payload(8'h55, 1'b0);
        offer_payload(8'hAA, 1'b1);
        wait_line_drained();

        while (items_sent < TargetItems) begin
            if (items_sent >= QuietFrom) begin
                quiet_tail = 1'b1;
            end
            if (!hold_done && items_sent >= LongHoldAt) begin
                hold_done = 1'b1;
                long_hold_req <= 1'b1;
                burst_mode = 1'b1;
                send_random_frame(24);
                burst_mode = 1'b0;
                wait_line_drained();
            end else begin
                case ($urandom_range(9, 0))
                    0, 1, 2: len = 1;
                    9:       len = $urandom_range(32, 9);
                    default: len = $urandom_range(8, 2);
                endcase
                send_random_frame(len);
            end
        end

        wait_line_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("stx_etx_frame_encoder_crc16 verification clean");
        end else begin
            $display("stx_etx_frame_encoder_crc16 verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/stx_pkg.sv
rtl/stx_if.sv
rtl/stx_front.sv
rtl/stx_queue.sv
rtl/stx_back.sv
rtl/stx_etx_frame_encoder_crc16.sv
bench/stx_frame_checker.sv
bench/tb_top.sv
